[rtl/core/ewmad_pkg.sv]
// Package with the request types, register indexes and constants of the EWMA ratio detector.
`default_nettype none

package ewmad_pkg;

	// Input request: channel selector, Q24.8 sample and nanosecond timestamp.
	typedef struct packed {
		logic        action;
		logic [31:0] sample_value;
		logic [63:0] timestamp_ns;
	} ewmad_sample_t;

	// Output request: kind of anomaly, Q8.16 ratio, triggering sample and its time.
	typedef struct packed {
		logic        anomaly_kind;
		logic [23:0] ratio;
		logic [31:0] observed_value;
		logic [63:0] event_time_ns;
	} ewmad_anomaly_t;

	// Configuration port geometry.
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_THR_ALPHA     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LAT_ALPHA     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DROP_TRIGGER  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPIKE_TRIGGER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REFRACTORY_MS = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_ALPHA         = 16'd6554;
	localparam logic [23:0] RST_DROP_TRIGGER  = 24'd32768;
	localparam logic [23:0] RST_SPIKE_TRIGGER = 24'd131072;
	localparam logic [31:0] RST_REFRACTORY_MS = 32'd1000;

	// Alpha clamp limits in Q0.16 (0.01 and 0.9).
	localparam logic [15:0] ALPHA_MIN = 16'd655;
	localparam logic [15:0] ALPHA_MAX = 16'd58982;

	// Refractory scaling and ratio limit.
	localparam int          REFR_NS_W   = 52;
	localparam logic [19:0] NS_PER_MS   = 20'd1000000;
	localparam logic [REFR_NS_W-1:0] RST_REFR_NS = 52'd1000000000;
	localparam logic [23:0] RATIO_MAX   = 24'hFFFFFF;

	// Serial step counts: one alpha bit per blend step, one quotient bit per divide step.
	localparam int BLEND_STEPS = 16;
	localparam int DIV_STEPS   = 24;

	// Channel codes.
	localparam logic CH_THROUGHPUT = 1'b0;
	localparam logic CH_LATENCY    = 1'b1;

endpackage

`default_nettype wire

[rtl/core/ewma_ratio_anomaly_detector_core.sv]
// Two-channel EWMA baseline ratio anomaly detector with bit-serial blend and divide.
//
// Usage: requests enter on the sample channel (sample_valid, sample_stall, sample) and
// anomaly reports leave on the anomaly channel (anomaly_valid, anomaly_stall, anomaly).
// A request is taken at a clock edge with valid high and stall low.
// The first sample of each channel only seeds its baseline and leaves sample_stall low.
// Every later sample keeps sample_stall high while it passes through the blend steps of
// a bit-serial multiply-accumulate that forms the new baseline (one alpha bit per cycle),
// the baseline update and saturation check states, the steps of a restoring divider (one
// quotient bit per cycle) and the decision state. A saturating ratio skips the divider.
// One sample is in work at a time. A report lands in an output register, so the next
// sample is taken while the report still waits; only a second report that finds the
// output register full waits in the decision state until the receiver drops anomaly_stall.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata; the
// user must write them only while the block is idle, which the block does not enforce.
// Reset (arst_n low) restores the register defaults, unprimes both channels, clears
// baselines and last flag times, and empties the output register.
`default_nettype none

module ewma_ratio_anomaly_detector_core
	import ewmad_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire ewmad_sample_t        sample,
	output logic                      anomaly_valid,
	input  wire logic                 anomaly_stall,
	output ewmad_anomaly_t            anomaly,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	// Sample width in use: the field is 32 bits, further masked to the value width.
	localparam int SW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_BLEND  = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;

	// Configuration registers.
	logic [15:0]          thr_alpha_q;
	logic [15:0]          lat_alpha_q;
	logic [23:0]          drop_trig_q;
	logic [23:0]          spike_trig_q;
	logic [31:0]          refr_ms_q;
	logic [REFR_NS_W-1:0] refr_ns_q;

	// Channel state.
	logic [SW-1:0] thr_base_q;
	logic [SW-1:0] lat_base_q;
	logic          thr_primed_q;
	logic          lat_primed_q;
	logic [63:0]   last_drop_q;
	logic [63:0]   last_spike_q;

	// Working registers of the item in flight.
	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ch_q;
	logic [SW-1:0]    smp_q;
	logic [63:0]      ts_q;
	logic [SW-1:0]    old_base_q;
	logic [15:0]      a_sr_q;
	logic [15:0]      w_sr_q;
	logic [SW:0]      acc_q;
	logic [SW-1:0]    den_q;
	logic [SW-1:0]    rem_q;
	logic [23:0]      num_sr_q;
	logic [23:0]      quo_q;
	logic             sat_q;
	logic [63:0]      diff_q;
	logic             hold_q;

	// Output register.
	logic           out_valid_q;
	ewmad_anomaly_t out_q;

	// Combinational helpers.
	logic            accept;
	logic            sel_primed;
	logic [SW-1:0]   sel_base;
	logic [63:0]     sel_last;
	logic [15:0]     sel_alpha;
	logic [15:0]     alpha_cl;
	logic [SW+1:0]   blend_sum;
	logic [SW:0]     div_trial;
	logic            div_ge;
	logic            inexact;
	logic            flag;
	logic            out_free;
	logic            emit;
	logic [SW-1:0]   new_base;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);

	// Per-channel selection at the time a request is taken.
	always_comb begin
		if (sample.action == CH_LATENCY) begin
			sel_primed = lat_primed_q;
			sel_base   = lat_base_q;
			sel_last   = last_spike_q;
			sel_alpha  = lat_alpha_q;
		end else begin
			sel_primed = thr_primed_q;
			sel_base   = thr_base_q;
			sel_last   = last_drop_q;
			sel_alpha  = thr_alpha_q;
		end
	end

	// Clamp alpha to the usable range.
	always_comb begin
		if (sel_alpha < ALPHA_MIN) begin
			alpha_cl = ALPHA_MIN;
		end else if (sel_alpha > ALPHA_MAX) begin
			alpha_cl = ALPHA_MAX;
		end else begin
			alpha_cl = sel_alpha;
		end
	end

	// One blend step, LSB first: add the weighted terms and, on the last step, the rounding bit, halve.
	assign blend_sum = {1'b0, acc_q}
		+ (a_sr_q[0] ? (SW+2)'(smp_q) : '0)
		+ (w_sr_q[0] ? (SW+2)'(old_base_q) : '0)
		+ (SW+2)'(cnt_q == CNT_W'(BLEND_STEPS - 1));

	// The blended value never exceeds the larger of sample and old baseline.
	assign new_base = acc_q[SW-1:0];

	// One restoring divide step.
	assign div_trial = {rem_q, num_sr_q[23]};
	assign div_ge    = (div_trial >= {1'b0, den_q});

	// Flag decision on the exact quotient.
	assign inexact = (rem_q != '0);
	always_comb begin
		if (ch_q == CH_LATENCY) begin
			flag = sat_q || (quo_q > spike_trig_q) || ((quo_q == spike_trig_q) && inexact);
		end else begin
			flag = !sat_q && (quo_q < drop_trig_q);
		end
	end

	assign out_free = !out_valid_q || !anomaly_stall;
	assign emit     = (state_q == ST_DECIDE) && flag && !hold_q && out_free;

	// Configuration writes and the refractory interval in nanoseconds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_alpha_q  <= RST_ALPHA;
			lat_alpha_q  <= RST_ALPHA;
			drop_trig_q  <= RST_DROP_TRIGGER;
			spike_trig_q <= RST_SPIKE_TRIGGER;
			refr_ms_q    <= RST_REFRACTORY_MS;
			refr_ns_q    <= RST_REFR_NS;
		end else begin
			refr_ns_q <= REFR_NS_W'(refr_ms_q) * REFR_NS_W'(NS_PER_MS);
			if (cfg_we) begin
				case (cfg_index)
					REG_THR_ALPHA:     thr_alpha_q  <= cfg_wdata[15:0];
					REG_LAT_ALPHA:     lat_alpha_q  <= cfg_wdata[15:0];
					REG_DROP_TRIGGER:  drop_trig_q  <= cfg_wdata[23:0];
					REG_SPIKE_TRIGGER: spike_trig_q <= cfg_wdata[23:0];
					REG_REFRACTORY_MS: refr_ms_q    <= cfg_wdata[31:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Sequencer with channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			thr_base_q   <= '0;
			lat_base_q   <= '0;
			thr_primed_q <= 1'b0;
			lat_primed_q <= 1'b0;
			last_drop_q  <= '0;
			last_spike_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!sel_primed) begin
							// First sample of a channel only seeds its baseline.
							if (sample.action == CH_LATENCY) begin
								lat_base_q   <= sample.sample_value[SW-1:0];
								lat_primed_q <= 1'b1;
							end else begin
								thr_base_q   <= sample.sample_value[SW-1:0];
								thr_primed_q <= 1'b1;
							end
						end else begin
							state_q <= ST_BLEND;
							cnt_q   <= '0;
						end
					end
				end
				ST_BLEND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(BLEND_STEPS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (ch_q == CH_LATENCY) begin
						lat_base_q <= new_base;
					end else begin
						thr_base_q <= new_base;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if ((smp_q >> 8) >= den_q) begin
						state_q <= ST_DECIDE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!flag || hold_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						if (ch_q == CH_LATENCY) begin
							last_spike_q <= ts_q;
						end else begin
							last_drop_q <= ts_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q       <= sample.action;
				smp_q      <= sample.sample_value[SW-1:0];
				ts_q       <= sample.timestamp_ns;
				old_base_q <= sel_base;
				a_sr_q     <= alpha_cl;
				w_sr_q     <= 16'(17'h10000 - {1'b0, alpha_cl});
				acc_q      <= '0;
				diff_q     <= sample.timestamp_ns - sel_last;
			end
			ST_BLEND: begin
				acc_q  <= blend_sum[SW+1:1];
				a_sr_q <= a_sr_q >> 1;
				w_sr_q <= w_sr_q >> 1;
			end
			ST_UPDATE: begin
				// Divisor is the baseline floored at 1.0.
				den_q  <= (new_base < SW'(256)) ? SW'(256) : new_base;
				hold_q <= (diff_q < 64'(refr_ns_q));
			end
			ST_CHECK: begin
				sat_q    <= ((smp_q >> 8) >= den_q);
				rem_q    <= smp_q >> 8;
				num_sr_q <= {smp_q[7:0], 16'h0000};
				quo_q    <= RATIO_MAX;
			end
			ST_DIV: begin
				num_sr_q <= num_sr_q << 1;
				quo_q    <= {quo_q[22:0], div_ge};
				if (div_ge) begin
					rem_q <= SW'(div_trial - {1'b0, den_q});
				end else begin
					rem_q <= div_trial[SW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a report until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !anomaly_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.anomaly_kind   <= ch_q;
			out_q.ratio          <= quo_q;
			out_q.observed_value <= 32'(smp_q);
			out_q.event_time_ns  <= ts_q;
		end
	end

	assign anomaly_valid = out_valid_q;
	assign anomaly       = out_q;

endmodule

`default_nettype wire
